FILE: rtl/bba_pkg.sv
// Shared types, codes and constants of the buddy block allocator.
package bba_pkg;

    localparam int POOL_ORDER_DEF = 16;
    localparam int MIN_ORDER_DEF  = 5;
    localparam int ORD_W          = 6;
    localparam int UNIT_W_MAX     = 29;
    localparam logic [7:0] HDR_RESET = 8'd40;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_RESIZE = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NULL     = 3'd1,
        ST_TOOLARGE = 3'd2,
        ST_NOMEM    = 3'd3,
        ST_NOTUSED  = 3'd4,
        ST_BADADDR  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_DONE   = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_RESIZE = 2'd3
    } t_op;

    typedef struct packed {
        t_op                     op;
        t_status                 status;
        logic                    zero;
        logic                    big;
        logic [ORD_W-1:0]        k;
        logic [UNIT_W_MAX-1:0]   unit;
    } t_cmd;

    typedef struct packed {
        logic [15:0] addr;
        logic        present;
        t_status     status;
        logic        moved;
        logic [4:0]  order;
    } t_res;

    function automatic t_res res_null(t_status st);
        t_res r;
        r         = '0;
        r.status  = st;
        return r;
    endfunction

endpackage

FILE: rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator: front stage, command queue, back stage, result queue.
//
// Binary buddy allocator over 2^POOL_ORDER bytes in units of 2^MIN_ORDER bytes. Requests
// enter through push/full and results leave through empty/pop, one result per request,
// in order. After reset the unit memory is swept once, one unit a cycle over its
// 2^(POOL_ORDER-MIN_ORDER) units (2048 by default), and full stays high until then.
// Every memory access of the back stage goes through the single read port of the unit
// memory: a request that needs no memory goes straight to its result, a free locates its
// block and then merges buddies, an allocate probes units in the search at the chosen
// order and then splits levels, and a moving resize adds the grow and free steps to an
// allocate. Write header_bytes only while no request is in flight.
module buddy_block_allocator #(
    parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
    parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [16:0] i_size_bytes,
    input  logic [15:0] i_payload_addr,
    input  logic        i_addr_present,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_result_addr,
    output logic        o_result_present,
    output logic [2:0]  o_status,
    output logic        o_moved,
    output logic [4:0]  o_granted_order,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);
    import bba_pkg::*;

    logic [7:0] r_header_bytes;
    t_cmd       front_cmd, back_cmd;
    t_res       back_res, out_res;
    logic       cmdq_full, cmdq_empty, cmd_pop;
    logic       res_full, res_push, clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_bytes <= HDR_RESET;
        end else if (i_cfg_we) begin
            r_header_bytes <= i_cfg_wdata;
        end
    end

    assign full = cmdq_full || clearing;

    bba_front #(.POOL_ORDER(POOL_ORDER), .MIN_ORDER(MIN_ORDER)) u_front (
        .i_action       (i_action),
        .i_size_bytes   (i_size_bytes),
        .i_payload_addr (i_payload_addr),
        .i_addr_present (i_addr_present),
        .i_hdr          (r_header_bytes),
        .o_cmd          (front_cmd)
    );

    bba_fifo #(.W($bits(t_cmd)), .DEPTH(2)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_wdata (front_cmd),
        .i_pop   (cmd_pop),
        .o_rdata (back_cmd),
        .o_full  (cmdq_full),
        .o_empty (cmdq_empty)
    );

    bba_back #(.POOL_ORDER(POOL_ORDER), .MIN_ORDER(MIN_ORDER)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hdr       (r_header_bytes),
        .i_cmd       (back_cmd),
        .i_cmd_empty (cmdq_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res),
        .o_clearing  (clearing)
    );

    bba_fifo #(.W($bits(t_res)), .DEPTH(2)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (back_res),
        .i_pop   (pop),
        .o_rdata (out_res),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_result_addr    = out_res.addr;
    assign o_result_present = out_res.present;
    assign o_status         = out_res.status;
    assign o_moved          = out_res.moved;
    assign o_granted_order  = out_res.order;
endmodule

FILE: rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/bba_fifo.sv
// Small register queue used for the command and result queues of the allocator.
module bba_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_full,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

FILE: rtl/bba_front.sv
// Front stage: classifies a request into a command for the back stage.
module bba_front #(
    parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
    parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF
) (
    input  logic [1:0]    i_action,
    input  logic [16:0]   i_size_bytes,
    input  logic [15:0]   i_payload_addr,
    input  logic          i_addr_present,
    input  logic [7:0]    i_hdr,
    output bba_pkg::t_cmd o_cmd
);
    import bba_pkg::*;

    logic [17:0]      s;
    logic             big, zero, bad;
    logic [ORD_W-1:0] k;
    logic [15:0]      b;
    logic             below, misal, outside;

    always_comb begin
        s    = 18'(i_size_bytes) + 18'(i_hdr);
        zero = (i_size_bytes == '0);
        big  = 34'(s) > (34'(1) << POOL_ORDER);
        k    = ORD_W'(POOL_ORDER);
        for (int o = POOL_ORDER; o >= MIN_ORDER; o--) begin
            if ((34'(1) << o) >= 34'(s)) begin
                k = ORD_W'(o);
            end
        end
    end

    always_comb begin
        below   = i_payload_addr < 16'(i_hdr);
        b       = i_payload_addr - 16'(i_hdr);
        misal   = (b & 16'((1 << MIN_ORDER) - 1)) != '0;
        outside = 33'(b >> MIN_ORDER) >= (33'(1) << (POOL_ORDER - MIN_ORDER));
        bad     = below || misal || outside;
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.k    = k;
        o_cmd.zero = zero;
        o_cmd.big  = big;
        o_cmd.unit = UNIT_W_MAX'(b >> MIN_ORDER);
        case (i_action)
            ACT_ALLOC, ACT_RESIZE: begin
                if (i_action == ACT_RESIZE && i_addr_present) begin
                    if (bad) begin
                        o_cmd.op     = OP_DONE;
                        o_cmd.status = ST_BADADDR;
                    end else begin
                        o_cmd.op = OP_RESIZE;
                    end
                end else if (zero) begin
                    o_cmd.op     = OP_DONE;
                    o_cmd.status = ST_NULL;
                end else if (big) begin
                    o_cmd.op     = OP_DONE;
                    o_cmd.status = ST_TOOLARGE;
                end else begin
                    o_cmd.op = OP_ALLOC;
                end
            end
            ACT_FREE: begin
                if (!i_addr_present) begin
                    o_cmd.op     = OP_DONE;
                    o_cmd.status = ST_NULL;
                end else if (bad) begin
                    o_cmd.op     = OP_DONE;
                    o_cmd.status = ST_BADADDR;
                end else begin
                    o_cmd.op = OP_FREE;
                end
            end
            default: begin
                o_cmd.op     = OP_DONE;
                o_cmd.status = ST_NULL;
            end
        endcase
    end
endmodule

FILE: rtl/bba_back.sv
// Back stage: sequencer that splits, merges and searches blocks in unit memory.
module bba_back #(
    parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
    parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_hdr,
    input  bba_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output bba_pkg::t_res o_res,
    output logic          o_clearing
);
    import bba_pkg::*;

    localparam int UW    = POOL_ORDER - MIN_ORDER;
    localparam int UNITS = 1 << UW;
    localparam int CW    = UW + 1;
    localparam int IW    = $clog2(POOL_ORDER + 1);
    localparam int AW    = POOL_ORDER + 1;

    typedef struct packed {
        logic             head;
        logic             used;
        logic [ORD_W-1:0] ord;
    } t_ent;

    typedef enum logic [12:0] {
        S_CLR   = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_LOC   = 13'b0000000000100,
        S_MRD   = 13'b0000000001000,
        S_MCHK  = 13'b0000000010000,
        S_MEND  = 13'b0000000100000,
        S_SPLIT = 13'b0000001000000,
        S_FIND  = 13'b0000010000000,
        S_ARD   = 13'b0000100000000,
        S_ACHK  = 13'b0001000000000,
        S_GRD   = 13'b0010000000000,
        S_GCHK  = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } t_state;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic             r_zero, n_zero, r_big, n_big, r_move, n_move;
    logic [ORD_W-1:0] r_k, n_k, r_o, n_o, r_i, n_i, r_oldo, n_oldo;
    logic [UW-1:0]    r_u, n_u, r_scan, n_scan, r_old, n_old, r_nu, n_nu;
    logic [UW-1:0]    r_clr;
    t_res             r_res, n_res;
    logic [CW-1:0]    r_fc [POOL_ORDER + 1];

    logic             wr_en;
    logic [UW-1:0]    wr_addr, rd_addr, spn, v, emit_u;
    t_ent             wr_data, d;
    logic [ORD_W+1:0] rd_raw;
    logic             fc_inc, fc_dec;
    logic [ORD_W-1:0] fc_idx, fidx;
    logic             found, match;
    logic [AW-1:0]    emit_a;

    bba_ram #(.W(ORD_W + 2), .D(UNITS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_raw)
    );

    always_comb begin
        found = 1'b0;
        fidx  = '0;
        for (int i = POOL_ORDER; i >= 0; i--) begin
            if (ORD_W'(i) >= r_k && r_fc[i] != '0) begin
                found = 1'b1;
                fidx  = ORD_W'(i);
            end
        end
    end

    always_comb begin
        d      = t_ent'(rd_raw);
        spn    = UW'(1) << (r_o - ORD_W'(MIN_ORDER));
        v      = r_u ^ spn;
        match  = d.head && !d.used && d.ord == r_o;
        emit_u = (r_state == S_MEND) ? r_nu : r_u;
        emit_a = (AW'(emit_u) << MIN_ORDER) + AW'(i_hdr);
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_zero   = r_zero;
        n_big    = r_big;
        n_move   = r_move;
        n_k      = r_k;
        n_o      = r_o;
        n_i      = r_i;
        n_oldo   = r_oldo;
        n_u      = r_u;
        n_scan   = r_scan;
        n_old    = r_old;
        n_nu     = r_nu;
        n_res    = r_res;
        wr_en    = 1'b0;
        wr_addr  = r_u;
        wr_data  = '0;
        rd_addr  = r_u;
        fc_inc   = 1'b0;
        fc_dec   = 1'b0;
        fc_idx   = r_o;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            S_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                if (r_clr == '0) begin
                    wr_data = '{head: 1'b1, used: 1'b0, ord: ORD_W'(POOL_ORDER)};
                end
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_op      = i_cmd.op;
                    n_zero    = i_cmd.zero;
                    n_big     = i_cmd.big;
                    n_k       = i_cmd.k;
                    n_u       = UW'(i_cmd.unit);
                    n_move    = 1'b0;
                    rd_addr   = UW'(i_cmd.unit);
                    case (i_cmd.op)
                        OP_DONE: begin
                            n_res   = res_null(i_cmd.status);
                            n_state = S_EMIT;
                        end
                        OP_ALLOC: n_state = S_FIND;
                        default:  n_state = S_LOC;
                    endcase
                end
            end
            S_LOC: begin
                n_o = d.ord;
                if (!d.head) begin
                    n_res   = res_null(ST_BADADDR);
                    n_state = S_EMIT;
                end else if (!d.used) begin
                    n_res   = res_null(ST_NOTUSED);
                    n_state = S_EMIT;
                end else if (r_op == OP_FREE || r_zero) begin
                    n_state = S_MRD;
                end else if (r_big) begin
                    n_res   = res_null(ST_TOOLARGE);
                    n_state = S_EMIT;
                end else if (d.ord >= r_k) begin
                    n_state = S_SPLIT;
                end else begin
                    n_state = S_GRD;
                end
            end
            S_MRD: begin
                rd_addr = v;
                n_state = (r_o >= ORD_W'(POOL_ORDER)) ? S_MEND : S_MCHK;
            end
            S_MCHK: begin
                if (match) begin
                    fc_dec  = 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = (v > r_u) ? v : r_u;
                    n_u     = (v > r_u) ? r_u : v;
                    n_o     = r_o + 1'b1;
                    n_state = S_MRD;
                end else begin
                    n_state = S_MEND;
                end
            end
            S_MEND: begin
                wr_en   = 1'b1;
                wr_data = '{head: 1'b1, used: 1'b0, ord: r_o};
                fc_inc  = 1'b1;
                if (r_move) begin
                    n_res         = '0;
                    n_res.addr    = 16'(emit_a);
                    n_res.present = 1'b1;
                    n_res.status  = ST_OK;
                    n_res.moved   = 1'b1;
                    n_res.order   = 5'(r_k);
                end else begin
                    n_res = res_null(ST_OK);
                end
                n_state = S_EMIT;
            end
            S_SPLIT: begin
                wr_en = 1'b1;
                if (r_o > r_k) begin
                    wr_addr = r_u + (UW'(1) << (r_o - 1'b1 - ORD_W'(MIN_ORDER)));
                    wr_data = '{head: 1'b1, used: 1'b0, ord: r_o - 1'b1};
                    fc_inc  = 1'b1;
                    fc_idx  = r_o - 1'b1;
                    n_o     = r_o - 1'b1;
                end else begin
                    wr_data = '{head: 1'b1, used: 1'b1, ord: r_k};
                    if (r_move) begin
                        n_nu    = r_u;
                        n_u     = r_old;
                        n_o     = r_oldo;
                        n_state = S_MRD;
                    end else begin
                        n_res         = '0;
                        n_res.addr    = 16'(emit_a);
                        n_res.present = 1'b1;
                        n_res.status  = ST_OK;
                        n_res.order   = 5'(r_k);
                        n_state       = S_EMIT;
                    end
                end
            end
            S_FIND: begin
                if (found) begin
                    n_i     = fidx;
                    n_scan  = '0;
                    n_state = S_ARD;
                end else begin
                    n_res   = res_null(ST_NOMEM);
                    n_state = S_EMIT;
                end
            end
            S_ARD: begin
                rd_addr = r_scan;
                n_state = S_ACHK;
            end
            S_ACHK: begin
                if (d.head && !d.used && d.ord == r_i) begin
                    fc_dec  = 1'b1;
                    fc_idx  = r_i;
                    n_u     = r_scan;
                    n_o     = r_i;
                    n_state = S_SPLIT;
                end else begin
                    n_scan  = r_scan + (UW'(1) << (r_i - ORD_W'(MIN_ORDER)));
                    n_state = S_ARD;
                end
            end
            S_GRD: begin
                rd_addr = v;
                if (r_o >= r_k || r_o >= ORD_W'(POOL_ORDER) || (r_u & spn) != '0) begin
                    wr_en   = 1'b1;
                    wr_data = '{head: 1'b1, used: 1'b1, ord: r_o};
                    if (r_o >= r_k) begin
                        n_res         = '0;
                        n_res.addr    = 16'(emit_a);
                        n_res.present = 1'b1;
                        n_res.status  = ST_OK;
                        n_res.order   = 5'(r_k);
                        n_state       = S_EMIT;
                    end else begin
                        n_old   = r_u;
                        n_oldo  = r_o;
                        n_move  = 1'b1;
                        n_state = S_FIND;
                    end
                end else begin
                    n_state = S_GCHK;
                end
            end
            S_GCHK: begin
                wr_en = 1'b1;
                if (match) begin
                    fc_dec  = 1'b1;
                    wr_addr = v;
                    n_o     = r_o + 1'b1;
                    n_state = S_GRD;
                end else begin
                    wr_data = '{head: 1'b1, used: 1'b1, ord: r_o};
                    n_old   = r_u;
                    n_oldo  = r_o;
                    n_move  = 1'b1;
                    n_state = S_FIND;
                end
            end
            S_EMIT: begin
                o_res_push = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_zero <= n_zero;
        r_big  <= n_big;
        r_k    <= n_k;
        r_o    <= n_o;
        r_i    <= n_i;
        r_oldo <= n_oldo;
        r_u    <= n_u;
        r_scan <= n_scan;
        r_old  <= n_old;
        r_nu   <= n_nu;
        r_res  <= n_res;
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_move  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_move  <= n_move;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= POOL_ORDER; i++) begin
            if (!i_rst_n) begin
                r_fc[i] <= (i == POOL_ORDER) ? CW'(1) : '0;
            end else if (fc_inc && fc_idx == ORD_W'(i)) begin
                r_fc[i] <= r_fc[i] + 1'b1;
            end else if (fc_dec && fc_idx == ORD_W'(i)) begin
                r_fc[i] <= r_fc[i] - 1'b1;
            end
        end
    end

    assign o_res      = r_res;
    assign o_clearing = (r_state == S_CLR);

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    a_fc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fc_dec |-> r_fc[fc_idx[IW-1:0]] != '0)
        else $error("free count taken below zero");

    a_clr_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_cmd_pop)
        else $error("command taken during clearing pass");

    a_mend_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEND) |=> (r_state == S_EMIT))
        else $error("merge end not followed by result");
endmodule

FILE: tb/sv/testbench.sv
// Testbench of the buddy block allocator: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

import bba_pkg::*;

class alloc_scoreboard;
    localparam int PO    = POOL_ORDER_DEF;
    localparam int MO    = MIN_ORDER_DEF;
    localparam int UNITS = 1 << (PO - MO);

    bit          is_head[UNITS];
    int unsigned ord[UNITS];
    bit          used[UNITS];
    int unsigned nfree[PO+1];
    int unsigned hdr;
    t_res        awaited[$];
    int          errors;

    function new();
        foreach (is_head[i]) begin
            is_head[i] = 0;
            ord[i]     = 0;
            used[i]    = 0;
        end
        foreach (nfree[i]) nfree[i] = 0;
        is_head[0] = 1;
        ord[0]     = PO;
        nfree[PO]  = 1;
        hdr        = HDR_RESET;
        errors     = 0;
    endfunction

    function int unsigned span(int unsigned o);
        return 1 << (o - MO);
    endfunction

    function void add_free(int unsigned u, int unsigned o);
        is_head[u] = 1;
        ord[u]     = o;
        used[u]    = 0;
        nfree[o]++;
    endfunction

    function void split_to(int unsigned u, int unsigned k);
        int unsigned o;
        while (ord[u] > k) begin
            o      = ord[u] - 1;
            ord[u] = o;
            add_free(u + span(o), o);
        end
    endfunction

    function void merge_free(int unsigned u);
        int unsigned o, v;
        forever begin
            o = ord[u];
            if (o >= PO) break;
            v = u ^ span(o);
            if (!is_head[v] || used[v] || ord[v] != o) break;
            nfree[o]--;
            if (v < u) begin
                is_head[u] = 0;
                used[u]    = 0;
                u          = v;
            end else begin
                is_head[v] = 0;
                used[v]    = 0;
            end
            ord[u] = o + 1;
        end
        add_free(u, ord[u]);
    endfunction

    function bit take_block(int unsigned k, output int unsigned res);
        res = 0;
        for (int unsigned i = k; i <= PO; i++) begin
            if (nfree[i] == 0) continue;
            for (int unsigned u = 0; u < UNITS; u += span(i)) begin
                if (is_head[u] && !used[u] && ord[u] == i) begin
                    nfree[i]--;
                    used[u] = 1;
                    split_to(u, k);
                    res = u;
                    return 1;
                end
            end
        end
        return 0;
    endfunction

    function bit order_for(int unsigned size, output int unsigned k);
        int unsigned s;
        s = size + hdr;
        k = MO;
        if (s > (1 << PO)) return 0;
        while ((1 << k) < s) k++;
        return 1;
    endfunction

    function t_status locate(int unsigned pa, output int unsigned u);
        int unsigned b;
        u = 0;
        if (pa < hdr) return ST_BADADDR;
        b = pa - hdr;
        if (b % (1 << MO) != 0) return ST_BADADDR;
        u = b >> MO;
        if (u >= UNITS) return ST_BADADDR;
        if (!is_head[u]) return ST_BADADDR;
        if (!used[u]) return ST_NOTUSED;
        return ST_OK;
    endfunction

    function t_res make_res(bit present, int unsigned u, t_status st, bit mv);
        t_res r;
        r        = '0;
        r.status = st;
        if (present) begin
            r.addr    = 16'((u << MO) + hdr);
            r.present = 1;
            r.moved   = mv;
            r.order   = 5'(ord[u]);
        end
        return r;
    endfunction

    function t_res do_alloc(int unsigned size);
        int unsigned k, u;
        if (size == 0) return make_res(0, 0, ST_NULL, 0);
        if (!order_for(size, k)) return make_res(0, 0, ST_TOOLARGE, 0);
        if (!take_block(k, u)) return make_res(0, 0, ST_NOMEM, 0);
        return make_res(1, u, ST_OK, 0);
    endfunction

    function t_res predict(logic [1:0] act, int unsigned size, int unsigned pa, bit present);
        int unsigned u, k, nu, o, v;
        t_status st;
        if (act == ACT_ALLOC) return do_alloc(size);
        if (act == ACT_FREE) begin
            if (!present) return make_res(0, 0, ST_NULL, 0);
            st = locate(pa, u);
            if (st != ST_OK) return make_res(0, 0, st, 0);
            merge_free(u);
            return make_res(0, 0, ST_OK, 0);
        end
        if (act == ACT_RESIZE) begin
            if (!present) return do_alloc(size);
            st = locate(pa, u);
            if (st != ST_OK) return make_res(0, 0, st, 0);
            if (size == 0) begin
                merge_free(u);
                return make_res(0, 0, ST_OK, 0);
            end
            if (!order_for(size, k)) return make_res(0, 0, ST_TOOLARGE, 0);
            if (ord[u] >= k) begin
                split_to(u, k);
                return make_res(1, u, ST_OK, 0);
            end
            while (ord[u] < k) begin
                o = ord[u];
                if (o >= PO) break;
                v = u ^ span(o);
                if (v < u) break;
                if (!is_head[v] || used[v] || ord[v] != o) break;
                nfree[o]--;
                is_head[v] = 0;
                used[v]    = 0;
                ord[u]     = o + 1;
            end
            if (ord[u] == k) return make_res(1, u, ST_OK, 0);
            if (!take_block(k, nu)) return make_res(0, 0, ST_NOMEM, 0);
            merge_free(u);
            return make_res(1, nu, ST_OK, 1);
        end
        return make_res(0, 0, ST_NULL, 0);
    endfunction

    function void note_request(logic [1:0] act, logic [16:0] size, logic [15:0] pa, logic present);
        awaited.push_back(predict(act, size, pa, present));
    endfunction

    function bit live_addr(output logic [15:0] a);
        int unsigned s, u;
        s = $urandom_range(0, UNITS - 1);
        a = '0;
        for (int unsigned i = 0; i < UNITS; i++) begin
            u = (s + i) % UNITS;
            if (is_head[u] && used[u]) begin
                a = 16'((u << MO) + hdr);
                return 1;
            end
        end
        return 0;
    endfunction

    function void check_result(logic [15:0] addr, logic present, logic [2:0] st, logic mv,
                               logic [4:0] go);
        t_res e;
        if (awaited.size() == 0) begin
            $error("result with nothing awaited");
            errors++;
            return;
        end
        e = awaited.pop_front();
        if (addr !== e.addr) begin
            $error("result_addr exp %0d act %0d", e.addr, addr);
            errors++;
        end
        if (present !== e.present) begin
            $error("result_present exp %0d act %0d", e.present, present);
            errors++;
        end
        if (st !== e.status) begin
            $error("status exp %0d act %0d", e.status, st);
            errors++;
        end
        if (mv !== e.moved) begin
            $error("moved exp %0d act %0d", e.moved, mv);
            errors++;
        end
        if (go !== e.order) begin
            $error("granted_order exp %0d act %0d", e.order, go);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam longint CYCLE_LIMIT = 40_000_000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [1:0]  i_action = '0;
    logic [16:0] i_size_bytes = '0;
    logic [15:0] i_payload_addr = '0;
    logic        i_addr_present = 0;
    logic        empty;
    logic        pop = 0;
    logic [15:0] o_result_addr;
    logic        o_result_present;
    logic [2:0]  o_status;
    logic        o_moved;
    logic [4:0]  o_granted_order;
    logic        i_cfg_we = 0;
    logic [7:0]  i_cfg_wdata = '0;

    alloc_scoreboard sb = new();
    longint cycles = 0;

    buddy_block_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_action(i_action), .i_size_bytes(i_size_bytes),
        .i_payload_addr(i_payload_addr), .i_addr_present(i_addr_present),
        .empty(empty), .pop(pop),
        .o_result_addr(o_result_addr), .o_result_present(o_result_present),
        .o_status(o_status), .o_moved(o_moved), .o_granted_order(o_granted_order),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // drain results with random stalls
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            @(negedge i_clk);
            if (gap > 0) begin
                pop = 0;
                repeat (gap) @(negedge i_clk);
            end
            pop = 1;
            do @(posedge i_clk); while (empty);
            sb.check_result(o_result_addr, o_result_present, o_status, o_moved,
                            o_granted_order);
        end
    end

    task automatic send(logic [1:0] act, logic [16:0] size, logic [15:0] pa, logic present);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        @(negedge i_clk);
        if (gap > 0) begin
            push = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_action       = act;
        i_size_bytes   = size;
        i_payload_addr = pa;
        i_addr_present = present;
        push           = 1;
        do @(posedge i_clk); while (full);
        sb.note_request(act, size, pa, present);
    endtask

    task automatic settle();
        @(negedge i_clk);
        push = 0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic write_header(logic [7:0] v);
        @(negedge i_clk);
        i_cfg_we    = 1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 0;
        sb.hdr      = v;
    endtask

    function automatic logic [16:0] pick_size();
        case ($urandom_range(0, 19))
            0:       return 17'd0;
            1:       return $urandom_range(0, 1) ? 17'd65536 : 17'(65536 - sb.hdr);
            2, 3:    return 17'($urandom_range(1, 65536));
            4, 5, 6, 7, 8, 9: return 17'($urandom_range(1, 1024));
            default: return 17'($urandom_range(1, 128));
        endcase
    endfunction

    task automatic random_items(int n);
        logic [15:0] a;
        int          r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 38) begin
                send(ACT_ALLOC, pick_size(), 16'($urandom), 1'($urandom));
            end else if (r < 68) begin
                if (sb.live_addr(a)) send(ACT_FREE, 17'($urandom), a, 1'b1);
                else send(ACT_ALLOC, pick_size(), 16'($urandom), 1'($urandom));
            end else if (r < 88) begin
                if (sb.live_addr(a)) send(ACT_RESIZE, pick_size(), a, 1'b1);
                else send(ACT_RESIZE, pick_size(), 16'($urandom), 1'b0);
            end else if (r < 95) begin
                send(2'($urandom_range(1, 2)), pick_size(), 16'($urandom), 1'($urandom));
            end else begin
                send(2'($urandom), 17'($urandom), 16'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send(ACT_ALLOC, 0, 0, 0);
        send(ACT_ALLOC, 17'd65536, 0, 0);
        send(ACT_FREE, 0, 0, 0);
        send(2'd3, 17'd100, 16'd40, 1);
        send(ACT_FREE, 0, 16'd0, 1);
        send(ACT_FREE, 0, 16'd41, 1);
        send(ACT_FREE, 0, 16'd40, 1);
        send(ACT_RESIZE, 17'd10, 16'd40, 1);
        send(ACT_ALLOC, 17'd1, 0, 0);
        send(ACT_RESIZE, 17'd200, 16'd40, 1);
        send(ACT_RESIZE, 17'd10, 16'd40, 1);
        send(ACT_ALLOC, 17'd32000, 0, 0);
        send(ACT_RESIZE, 17'd30000, 16'd40, 1);
        send(ACT_ALLOC, 17'd100, 0, 0);
        send(ACT_RESIZE, 17'd65000, 16'd40, 1);
        send(ACT_RESIZE, 17'd65536, 16'd40, 1);
        send(ACT_FREE, 0, 16'd32808, 1);
        send(ACT_RESIZE, 17'd40000, 16'd40, 1);
        send(ACT_RESIZE, 0, 16'd40, 1);
        send(ACT_RESIZE, 17'd100, 16'd0, 0);
        send(ACT_ALLOC, 17'd100, 0, 0);
        send(ACT_RESIZE, 17'd500, 16'd40, 1);
        send(ACT_FREE, 0, 16'hFFFF, 1);
        random_items(300);
        settle();

        write_header(8'd0);
        send(ACT_ALLOC, 17'd65536, 0, 0);
        random_items(300);
        settle();

        write_header(8'd255);
        random_items(300);
        settle();

        write_header(8'($urandom_range(1, 254)));
        random_items(250);
        settle();

        if (sb.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

FILE: buddy_block_allocator.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_fifo.sv
rtl/bba_front.sv
rtl/bba_back.sv
rtl/buddy_block_allocator.sv
tb/sv/testbench.sv
